/* rtl/sndscan_pkg.sv */
// Package for the signed number to digit scan: field widths, symbol codes,
// the pipeline item type and the shift-and-add-three step used by each cell.
// No dependencies.
`default_nettype none

package sndscan_pkg;

   // Field widths
   localparam int VALUE_W    = 16;
   localparam int MAG_W      = 14;   // magnitudes up to 9999
   localparam int NUM_DIGITS = 4;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int POS_W      = 3;
   localparam int SYM_W      = 4;

   // One cell per magnitude bit
   localparam int STAGES = MAG_W;

   // Range limits of the two displayable classes
   localparam logic signed [VALUE_W-1:0] POS_LIMIT = 16'sd9999;
   localparam logic signed [VALUE_W-1:0] NEG_LIMIT = -16'sd999;

   // Symbol and position codes
   localparam logic [SYM_W-1:0] SYM_DASH  = 4'd10;
   localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
   localparam logic [POS_W-1:0] POS_LAST  = 3'd4;

   typedef enum logic [1:0] {
      KIND_POS  = 2'd0,
      KIND_NEG  = 2'd1,
      KIND_DASH = 2'd2
   } kind_type;

   // One item as it moves along the row of cells
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BCD_W-1:0]  bcd;
      logic [MAG_W-1:0]  bin;
   } stage_type;

   // Adjust every BCD digit of five or more by three, then shift one binary bit in
   function automatic logic [BCD_W+MAG_W-1:0] dabble_step(
      input logic [BCD_W-1:0] bcd,
      input logic [MAG_W-1:0] bin
   );
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end
      end
      return {adj, bin} << 1;
   endfunction

endpackage : sndscan_pkg

`default_nettype wire

/* rtl/signed_number_to_digit_scan.sv */
// Top level of the signed number to digit scan: classifies the input, runs
// the magnitude through a row of sndscan_cell and issues results from
// sndscan_emit. Depends on sndscan_pkg.
//
// Use: present a signed 16-bit number on req_value with req_valid; it is
// taken on a clock edge where req_stall is low. Each number produces a run
// of (rsp_position, rsp_symbol) results, rsp_last marking the final one:
// 0..9999 gives its digits rightmost first without leading zeros, -998..-1
// gives its magnitude digits then a minus sign to their left, anything else
// gives four dashes at positions 1 to 4. Symbol 10 is the dash.
// The row has one cell per magnitude bit (14); an item passes through every
// cell and is registered into the sequencer before its first result shows.
// Throughput: numbers enter back to back while req_stall is low; the sequencer
// issues one result a cycle unless rsp_stall holds it, and an item gives 1 to 4
// results. The whole row moves together and halts while its last cell holds an
// item and the sequencer is still busy with an earlier run.
// Reset clears every valid flag; no result is pending afterwards.
// While rsp_stall is high the current result holds; req_stall rises whenever
// the last cell holds an item that the sequencer cannot take yet.
`default_nettype none

module signed_number_to_digit_scan
   import sndscan_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POS_W-1:0]          rsp_position,
   output logic [SYM_W-1:0]          rsp_symbol,
   output logic                      rsp_last
);

   stage_type        chain [0:STAGES];
   logic             advance;
   logic             take;
   logic             is_pos;
   logic             is_neg;
   logic [VALUE_W-1:0] neg_value;
   logic [MAG_W-1:0] mag;
   kind_type         kind;

   // Classify the number and form its magnitude
   assign is_pos    = !req_value[VALUE_W-1] && (req_value <= POS_LIMIT);
   assign is_neg    = req_value[VALUE_W-1] && (req_value > NEG_LIMIT);
   assign neg_value = VALUE_W'(0) - VALUE_W'(req_value);

   always_comb begin
      if (is_pos) begin
         kind = KIND_POS;
         mag  = req_value[MAG_W-1:0];
      end else if (is_neg) begin
         kind = KIND_NEG;
         mag  = neg_value[MAG_W-1:0];
      end else begin
         kind = KIND_DASH;
         mag  = '0;
      end
   end

   always_comb begin
      chain[0].valid = req_valid;
      chain[0].kind  = kind;
      chain[0].bcd   = '0;
      chain[0].bin   = mag;
   end

   // Move the row unless its end holds an item the sequencer cannot take
   assign advance   = !chain[STAGES].valid || take;
   assign req_stall = !advance;

   // Row of conversion cells
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      sndscan_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_stage (chain[i]),
         .out_stage(chain[i+1])
      );
   end

   sndscan_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .tail        (chain[STAGES]),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_position(rsp_position),
      .rsp_symbol  (rsp_symbol),
      .rsp_last    (rsp_last)
   );

`ifndef SYNTHESIS
   // An accepted item occupies the first cell on the next cycle
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> chain[1].valid)
      else $error("accepted item did not enter the cell row");

   // Positions shown stay on the display
   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position >= POS_FIRST && rsp_position <= POS_LAST))
      else $error("result position out of range");

   // Symbols are digits or the dash
   a_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol <= SYM_DASH))
      else $error("result symbol out of range");

   // The row only halts when its end waits on a busy sequencer
   a_halt: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (chain[STAGES].valid && rsp_valid))
      else $error("cell row halted without cause");
`endif

endmodule : signed_number_to_digit_scan

`default_nettype wire

/* rtl/sndscan_cell.sv */
// One cell of the binary to BCD row: performs a single shift-and-add-three
// step and hands the item on to its neighbour. Depends on sndscan_pkg.
`default_nettype none

module sndscan_cell
   import sndscan_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type in_stage,
   output stage_type out_stage
);

   stage_type stage_ff;
   stage_type stage_in;
   logic [BCD_W+MAG_W-1:0] step;

   // Work one bit of the conversion
   assign step = dabble_step(in_stage.bcd, in_stage.bin);

   always_comb begin
      stage_in.valid = in_stage.valid;
      stage_in.kind  = in_stage.kind;
      stage_in.bcd   = step[BCD_W+MAG_W-1:MAG_W];
      stage_in.bin   = step[MAG_W-1:0];
   end

   // Clear the valid flag under reset, advance the payload with the row
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.kind <= stage_in.kind;
         stage_ff.bcd  <= stage_in.bcd;
         stage_ff.bin  <= stage_in.bin;
      end
   end

   assign out_stage = stage_ff;

endmodule : sndscan_cell

`default_nettype wire

/* rtl/sndscan_emit.sv */
// Result sequencer, depends on sndscan_pkg: takes a converted item from the
// cell row end, issues its position and symbol results one per unstalled cycle.
`default_nettype none

module sndscan_emit
   import sndscan_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stage_type        tail,
   output logic             take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [POS_W-1:0] rsp_position,
   output logic [SYM_W-1:0] rsp_symbol,
   output logic             rsp_last
);

   logic             busy_ff, busy_in;
   kind_type         kind_ff, kind_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] stop_ff, stop_in;
   logic             sign_ff, sign_in;

   logic             fire;
   logic [SYM_W-1:0] nibble;
   logic [SYM_W-1:0] sym_c;
   logic             last_c;
   logic [POS_W-1:0] stop_new;

   assign fire = busy_ff && !rsp_stall;
   assign take = tail.valid && (!busy_ff || (fire && last_c));

   // Pick the digit shown at the current position
   always_comb begin
      unique case (pos_ff)
         3'd1:    nibble = bcd_ff[15:12];
         3'd2:    nibble = bcd_ff[11:8];
         3'd3:    nibble = bcd_ff[7:4];
         default: nibble = bcd_ff[3:0];
      endcase
   end

   // Decode symbol and end of run from the held item
   always_comb begin
      unique case (kind_ff)
         KIND_POS: begin
            sym_c  = nibble;
            last_c = (pos_ff == stop_ff);
         end
         KIND_NEG: begin
            sym_c  = sign_ff ? SYM_DASH : nibble;
            last_c = sign_ff;
         end
         default: begin
            sym_c  = SYM_DASH;
            last_c = (pos_ff == POS_LAST);
         end
      endcase
   end

   // Leftmost digit position: drop leading zeros, keep a lone zero
   always_comb begin
      if (tail.bcd[15:12] != 4'd0) begin
         stop_new = 3'd1;
      end else if (tail.bcd[11:8] != 4'd0) begin
         stop_new = 3'd2;
      end else if (tail.bcd[7:4] != 4'd0) begin
         stop_new = 3'd3;
      end else begin
         stop_new = POS_LAST;
      end
   end

   // Step through the run; load the next item when idle or as the last result leaves
   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      bcd_in  = bcd_ff;
      pos_in  = pos_ff;
      stop_in = stop_ff;
      sign_in = sign_ff;
      if (fire) begin
         if (last_c) begin
            busy_in = 1'b0;
         end else begin
            unique case (kind_ff)
               KIND_NEG: begin
                  if (pos_ff == stop_ff) begin
                     sign_in = 1'b1;
                     pos_in  = stop_ff - 3'd1;
                  end else begin
                     pos_in = pos_ff - 3'd1;
                  end
               end
               KIND_POS: begin
                  pos_in = pos_ff - 3'd1;
               end
               default: begin
                  pos_in = pos_ff + 3'd1;
               end
            endcase
         end
      end
      if (take) begin
         busy_in = 1'b1;
         kind_in = tail.kind;
         bcd_in  = tail.bcd;
         sign_in = 1'b0;
         stop_in = stop_new;
         pos_in  = (tail.kind == KIND_POS || tail.kind == KIND_NEG) ? POS_LAST : POS_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      bcd_ff  <= bcd_in;
      pos_ff  <= pos_in;
      stop_ff <= stop_in;
      sign_ff <= sign_in;
   end

   assign rsp_valid    = busy_ff;
   assign rsp_position = pos_ff;
   assign rsp_symbol   = sym_c;
   assign rsp_last     = last_c;

endmodule : sndscan_emit

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for signed_number_to_digit_scan: directed and random
// numbers in, each (position, symbol, last) result checked against a local model.
// Depends on sndscan_pkg and the signed_number_to_digit_scan RTL.
`default_nettype none

module tb
   import sndscan_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [POS_W-1:0] position;
      logic [SYM_W-1:0] symbol;
      logic             last;
   } scan_result_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [POS_W-1:0]          rsp_position;
   logic [SYM_W-1:0]          rsp_symbol;
   logic                      rsp_last;

   scan_result_type expected_digits[$];
   int unsigned  error_count    = 0;
   int unsigned  numbers_sent   = 0;
   int unsigned  results_seen   = 0;
   int unsigned  dash_numbers   = 0;
   int unsigned  minus_numbers  = 0;
   bit           req_quiet      = 1'b0;
   bit           rsp_quiet      = 1'b0;

   signed_number_to_digit_scan dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_position (rsp_position),
      .rsp_symbol   (rsp_symbol),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #(1_000_000);
      $display("%0t: timeout, %0d results still awaited", $time, expected_digits.size());
      $display("signed_number_to_digit_scan regression: fail");
      $finish;
   end

   function automatic void push_result(int pos, int sym, bit is_last);
      scan_result_type r;
      r.position = pos[POS_W-1:0];
      r.symbol   = sym[SYM_W-1:0];
      r.last     = is_last;
      expected_digits.push_back(r);
   endfunction

   // Work out the display run for one number and queue it
   function automatic void predict_scan(logic signed [VALUE_W-1:0] v);
      int mag;
      int ndig;
      int pos;
      bit neg;
      if ((v >= 0 && v <= POS_LIMIT) || (v < 0 && v > NEG_LIMIT)) begin
         neg  = (v < 0);
         mag  = neg ? -int'(v) : int'(v);
         ndig = (mag > 999) ? 4 : (mag > 99) ? 3 : (mag > 9) ? 2 : 1;
         // units at the rightmost position, moving left
         for (pos = NUM_DIGITS; pos > NUM_DIGITS - ndig; pos--) begin
            push_result(pos, (mag / (10 ** (NUM_DIGITS - pos))) % 10,
                        !neg && pos == NUM_DIGITS - ndig + 1);
         end
         if (neg) begin
            push_result(NUM_DIGITS - ndig, SYM_DASH, 1'b1);
            minus_numbers++;
         end
      end else begin
         for (pos = 1; pos <= NUM_DIGITS; pos++) begin
            push_result(pos, SYM_DASH, pos == NUM_DIGITS);
         end
         dash_numbers++;
      end
   endfunction

   // Present one number after a random gap and hold it until taken
   task automatic send_number(int v);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= VALUE_W'(v);
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_scan(VALUE_W'(v));
      numbers_sent++;
   endtask

   // Hold off the sender until every queued result has come out
   task automatic wait_display_idle();
      req_valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   task automatic check_result();
      scan_result_type want;
      results_seen++;
      if (expected_digits.size() == 0) begin
         $display("%0t: unexpected result position %0d symbol %0d last %0d",
                  $time, rsp_position, rsp_symbol, rsp_last);
         error_count++;
      end else begin
         want = expected_digits.pop_front();
         if (rsp_position !== want.position) begin
            $display("%0t: position expected %0d got %0d", $time, want.position, rsp_position);
            error_count++;
         end
         if (rsp_symbol !== want.symbol) begin
            $display("%0t: symbol expected %0d got %0d", $time, want.symbol, rsp_symbol);
            error_count++;
         end
         if (rsp_last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, rsp_last);
            error_count++;
         end
      end
   endtask

   // Take results and stall a random number of cycles after each one
   initial begin : result_monitor
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            check_result();
            hold = rsp_quiet ? 0 : $urandom_range(0, 13);
         end else if (hold != 0) begin
            hold--;
         end
         rsp_stall <= (hold != 0);
      end
   end

   function automatic int draw_value();
      int sel;
      int ndig;
      int lo;
      int hi;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         // non-negative, spread evenly over digit counts
         ndig = $urandom_range(1, NUM_DIGITS);
         lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
         hi   = 10 ** ndig - 1;
         return lo + int'($urandom_range(0, hi - lo));
      end else if (sel < 7) begin
         // negative with a minus sign, spread over magnitude lengths
         ndig = $urandom_range(1, 3);
         lo   = (ndig == 1) ? 1 : 10 ** (ndig - 1);
         hi   = (ndig == 3) ? 998 : 10 ** ndig - 1;
         return -(lo + int'($urandom_range(0, hi - lo)));
      end else if (sel == 7) begin
         case ($urandom_range(0, 7))
            0: return 9998;
            1: return 9999;
            2: return 10000;
            3: return -997;
            4: return -998;
            5: return -999;
            6: return -1000;
            default: return 0;
         endcase
      end
      return int'($urandom_range(0, 65535));
   endfunction

   task automatic test_positive_digits();
      send_number(0);
      send_number(1);
      send_number(9);
      send_number(10);
      send_number(99);
      send_number(100);
      send_number(999);
      send_number(1000);
      send_number(9999);
      send_number(10000);
   endtask

   task automatic test_negative_digits();
      send_number(-1);
      send_number(-9);
      send_number(-10);
      send_number(-99);
      send_number(-100);
      send_number(-998);
   endtask

   task automatic test_dash_values();
      // minus nine hundred ninety-nine sits just outside the negative range
      send_number(-999);
      send_number(-1000);
      send_number(16'sh7FFF);
      send_number(16'sh8000);
      send_number(16'sh5555);
      send_number(16'shAAAA);
   endtask

   // Random numbers with bursts of back-to-back traffic and free-running output
   task automatic test_random_mix();
      int i;
      for (i = 0; i < 470; i++) begin
         if (i % 40 == 0) begin
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         send_number(draw_value());
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_positive_digits();
      test_negative_digits();
      wait_display_idle();
      test_dash_values();
      test_random_mix();
      wait_display_idle();
      repeat (40) @(posedge clock);
      $display("Sent %0d numbers (%0d with minus sign, %0d shown as dashes); checked %0d results.",
               numbers_sent, minus_numbers, dash_numbers, results_seen);
      if (error_count == 0) begin
         $display("signed_number_to_digit_scan regression: pass");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("signed_number_to_digit_scan regression: fail");
      end
      $finish;
   end

endmodule : tb

`default_nettype wire

/* files.f */
rtl/sndscan_pkg.sv
rtl/sndscan_cell.sv
rtl/sndscan_emit.sv
rtl/signed_number_to_digit_scan.sv
verif/tb.sv
